// ----- hdl/lla_pkg.sv -----
// Shared constants for the Life-like automaton generation block.
// Grid dimensions, address layout, operation codes and register indexes.
// No dependencies.
package lla_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DIM_W  = 7;
    localparam int ADDR_W = 1 + ROW_W + COL_W;
    localparam int DEPTH  = 2 * MAX_ROWS * MAX_COLUMNS;

    localparam int CELL_W  = 8;
    localparam int COUNT_W = 4;
    localparam int IDX_W   = 3;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_GEN   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_BIRTH_COUNT = 3'd2;
    localparam logic [IDX_W-1:0] REG_SURVIVE_MIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_SURVIVE_MAX = 3'd4;
    localparam logic [IDX_W-1:0] REG_ALIVE_VALUE = 3'd5;
    localparam logic [IDX_W-1:0] REG_DECAY_STEP  = 3'd6;

endpackage

// ----- hdl/lla_if.sv -----
// Valid/ready channel interfaces for the Life-like automaton block.
// Depends on lla_pkg for field widths.
interface lla_in_if import lla_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, func, column, row, cell_value, input ready);
    modport sink   (input valid, func, column, row, cell_value, output ready);
endinterface

interface lla_out_if import lla_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] read_value;
    logic [1:0]        done_kind;

    modport source (output valid, read_value, done_kind, input ready);
    modport sink   (input valid, read_value, done_kind, output ready);
endinterface

// ----- hdl/lla_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/life_like_automaton_generation_top.sv -----
// Top level of the Life-like automaton generation block.
// Depends on lla_pkg, lla_if (channel interfaces) and lla_ram (cell store).

// The block keeps two banks of 64 by 64 eight-bit cells in one RAM; one bank
// is the visible grid. A word on the input channel writes a cell, reads a
// cell or runs one generation, and every word returns exactly one result word.
// After reset the block sweeps the whole RAM to zero, one entry per cycle;
// no input word is taken during that sweep, while configuration writes are
// accepted at any time. A write stores the cell when the word is taken and a
// read captures the stored cell in ST_READ; both then pass through ST_FINISH,
// which loads the result word into the output register once that is free.
// A generation walks the grid row by row through the single RAM read port.
// The start loads the alive flags of three rows, the row above row zero,
// row zero and the row below it. Every later row in use first loads the
// alive flags of the row below it. Every row then reads all 64 columns and
// writes the new values into the other bank. Cells outside the grid in use
// are copied unchanged. The result word waits in an output register, so
// the block may accept the next word meanwhile.
module life_like_automaton_generation_top import lla_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    lla_in_if.sink             items,
    lla_out_if.source          results,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CELL_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FINISH,
        ST_LOAD,
        ST_LOAD_DRAIN,
        ST_COMP,
        ST_COMP_DRAIN
    } state_t;

    // Configuration registers.
    logic [DIM_W-1:0]   grid_width_reg;
    logic [DIM_W-1:0]   grid_height_reg;
    logic [COUNT_W-1:0] birth_count_reg;
    logic [COUNT_W-1:0] survive_min_reg;
    logic [COUNT_W-1:0] survive_max_reg;
    logic [CELL_W-1:0]  alive_value_reg;
    logic [CELL_W-1:0]  decay_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(MAX_COLUMNS);
            grid_height_reg <= DIM_W'(MAX_ROWS);
            birth_count_reg <= COUNT_W'(3);
            survive_min_reg <= COUNT_W'(2);
            survive_max_reg <= COUNT_W'(3);
            alive_value_reg <= CELL_W'(255);
            decay_step_reg  <= CELL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                REG_BIRTH_COUNT: birth_count_reg <= cfg_data[COUNT_W-1:0];
                REG_SURVIVE_MIN: survive_min_reg <= cfg_data[COUNT_W-1:0];
                REG_SURVIVE_MAX: survive_max_reg <= cfg_data[COUNT_W-1:0];
                REG_ALIVE_VALUE: alive_value_reg <= cfg_data;
                REG_DECAY_STEP:  decay_step_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Grid size in use: the registers clamped to three and to the store size.
    logic [DIM_W-1:0] w_use;
    logic [DIM_W-1:0] h_use;

    always_comb
    begin
        if (grid_width_reg < DIM_W'(3))
            w_use = DIM_W'(3);
        else if (grid_width_reg > DIM_W'(MAX_COLUMNS))
            w_use = DIM_W'(MAX_COLUMNS);
        else
            w_use = grid_width_reg;

        if (grid_height_reg < DIM_W'(3))
            h_use = DIM_W'(3);
        else if (grid_height_reg > DIM_W'(MAX_ROWS))
            h_use = DIM_W'(MAX_ROWS);
        else
            h_use = grid_height_reg;
    end

    // Control and sequencing registers.
    state_t              state_reg,     state_next;
    logic                bank_reg,      bank_next;
    logic [ADDR_W-1:0]   clr_addr_reg,  clr_addr_next;
    logic [ROW_W-1:0]    row_reg,       row_next;
    logic [ROW_W-1:0]    load_row_reg,  load_row_next;
    logic [COL_W-1:0]    col_reg,       col_next;
    logic [1:0]          loads_left_reg, loads_left_next;
    logic                p_valid_reg,   p_valid_next;
    logic                p_load_reg,    p_load_next;
    logic [COL_W-1:0]    p_col_reg,     p_col_next;
    logic                rd_inside_reg, rd_inside_next;
    logic [CELL_W-1:0]   res_value_reg, res_value_next;
    logic [1:0]          res_kind_reg,  res_kind_next;
    logic                out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]   out_value_reg, out_value_next;
    logic [1:0]          out_kind_reg,  out_kind_next;

    // Alive flags of the rows above, at and below the row being computed.
    logic [MAX_COLUMNS-1:0] above_reg, above_next;
    logic [MAX_COLUMNS-1:0] mid_reg,   mid_next;
    logic [MAX_COLUMNS-1:0] below_reg, below_next;

    // Cell store port signals.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    lla_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next value of the cell whose stored value has just come back.
    logic [COL_W-1:0]   cm;
    logic [COL_W-1:0]   cp;
    logic [COUNT_W-1:0] nbr_count;
    logic               is_alive;
    logic               stays_alive;
    logic               in_grid;
    logic [CELL_W-1:0]  decayed;
    logic [CELL_W-1:0]  gen_value;

    always_comb
    begin
        cm = (p_col_reg == '0) ? COL_W'(w_use - DIM_W'(1)) : p_col_reg - COL_W'(1);
        cp = ({1'b0, p_col_reg} + DIM_W'(1) == w_use) ? '0 : p_col_reg + COL_W'(1);
        nbr_count = COUNT_W'(above_reg[cm]) + COUNT_W'(above_reg[p_col_reg])
                  + COUNT_W'(above_reg[cp]) + COUNT_W'(mid_reg[cm])
                  + COUNT_W'(mid_reg[cp])   + COUNT_W'(below_reg[cm])
                  + COUNT_W'(below_reg[p_col_reg]) + COUNT_W'(below_reg[cp]);
        is_alive = (ram_rdata == alive_value_reg);
        stays_alive = (!is_alive && nbr_count == birth_count_reg)
                   || (is_alive && nbr_count >= survive_min_reg
                       && nbr_count <= survive_max_reg);
        in_grid = ({1'b0, row_reg} < h_use) && ({1'b0, p_col_reg} < w_use);
        decayed = (ram_rdata >= decay_step_reg) ? ram_rdata - decay_step_reg : '0;
        if (!in_grid)
            gen_value = ram_rdata;
        else if (stays_alive)
            gen_value = alive_value_reg;
        else
            gen_value = decayed;
    end

    logic item_take;
    logic item_inside;
    logic gen_write;

    assign items.ready = (state_reg == ST_IDLE);
    assign item_take   = items.valid && items.ready;
    assign item_inside = ({1'b0, items.column} < w_use) && ({1'b0, items.row} < h_use);
    assign gen_write   = p_valid_reg && !p_load_reg;

    assign results.valid      = out_valid_reg;
    assign results.read_value = out_value_reg;
    assign results.done_kind  = out_kind_reg;

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        clr_addr_next   = clr_addr_reg;
        row_next        = row_reg;
        load_row_next   = load_row_reg;
        col_next        = col_reg;
        loads_left_next = loads_left_reg;
        p_valid_next    = 1'b0;
        p_load_next     = p_load_reg;
        p_col_next      = p_col_reg;
        rd_inside_next  = rd_inside_reg;
        res_value_next  = res_value_reg;
        res_kind_next   = res_kind_reg;
        out_value_next  = out_value_reg;
        out_kind_next   = out_kind_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        above_next      = above_reg;
        mid_next        = mid_reg;
        below_next      = below_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        // Returning read data of the generation pipeline.
        if (p_valid_reg && p_load_reg)
        begin
            below_next[p_col_reg] = is_alive;
        end
        if (gen_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = {~bank_reg, row_reg, p_col_reg};
            ram_wdata = gen_value;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_take)
                begin
                    res_kind_next  = items.func;
                    res_value_next = '0;
                    unique case (items.func)
                        FUNC_WRITE:
                        begin
                            ram_we     = item_inside;
                            ram_waddr  = {bank_reg, items.row, items.column};
                            ram_wdata  = items.cell_value;
                            state_next = ST_FINISH;
                        end
                        FUNC_GEN:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            load_row_next   = ROW_W'(h_use - DIM_W'(1));
                            loads_left_next = 2'd2;
                            state_next      = ST_LOAD;
                        end
                        FUNC_READ:
                        begin
                            ram_re         = item_inside;
                            ram_raddr      = {bank_reg, items.row, items.column};
                            rd_inside_next = item_inside;
                            state_next     = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_value_next = rd_inside_reg ? ram_rdata : '0;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_kind_next  = res_kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                // A new row enters at the bottom of the three-row window.
                if (col_reg == '0)
                begin
                    above_next = mid_reg;
                    mid_next   = below_reg;
                end
                ram_re       = 1'b1;
                ram_raddr    = {bank_reg, load_row_reg, col_reg};
                p_valid_next = 1'b1;
                p_load_next  = 1'b1;
                p_col_next   = col_reg;
                if ({1'b0, col_reg} == w_use - DIM_W'(1))
                    state_next = ST_LOAD_DRAIN;
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_LOAD_DRAIN:
            begin
                col_next = '0;
                if ({1'b0, load_row_reg} + DIM_W'(1) == h_use)
                    load_row_next = '0;
                else
                    load_row_next = load_row_reg + ROW_W'(1);
                if (loads_left_reg != 2'd0)
                begin
                    loads_left_next = loads_left_reg - 2'd1;
                    state_next      = ST_LOAD;
                end
                else
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                ram_re       = 1'b1;
                ram_raddr    = {bank_reg, row_reg, col_reg};
                p_valid_next = 1'b1;
                p_load_next  = 1'b0;
                p_col_next   = col_reg;
                if (col_reg == COL_W'(MAX_COLUMNS - 1))
                    state_next = ST_COMP_DRAIN;
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_COMP_DRAIN:
            begin
                col_next = '0;
                if (row_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    bank_next  = ~bank_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    row_next        = row_reg + ROW_W'(1);
                    loads_left_next = 2'd0;
                    // Rows past the grid in use are only copied.
                    if ({1'b0, row_reg} + DIM_W'(2) <= h_use)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_COMP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            bank_reg       <= 1'b0;
            clr_addr_reg   <= '0;
            row_reg        <= '0;
            load_row_reg   <= '0;
            col_reg        <= '0;
            loads_left_reg <= '0;
            p_valid_reg    <= 1'b0;
            p_load_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            clr_addr_reg   <= clr_addr_next;
            row_reg        <= row_next;
            load_row_reg   <= load_row_next;
            col_reg        <= col_next;
            loads_left_reg <= loads_left_next;
            p_valid_reg    <= p_valid_next;
            p_load_reg     <= p_load_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_col_reg     <= p_col_next;
        rd_inside_reg <= rd_inside_next;
        res_value_reg <= res_value_next;
        res_kind_reg  <= res_kind_next;
        out_value_reg <= out_value_next;
        out_kind_reg  <= out_kind_next;
        above_reg     <= above_next;
        mid_reg       <= mid_next;
        below_reg     <= below_next;
    end

    // A generation never writes into the bank it is reading.
    a_gen_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
        gen_write |-> ram_waddr[ADDR_W-1] != bank_reg)
        else $error("generation write hit the visible bank");

    // Only one word is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> !items.ready)
        else $error("second word taken while one is in work");

    // The generation pipeline is empty whenever the block is idle.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !p_valid_reg)
        else $error("pipeline data left over in idle");

endmodule
